// File: sv/ltfg_pkg.sv
// ----------------------------------------------------------------------------
// ltfg_pkg
// shared widths, register indexes, reset values and datapath types for the
// load and thermal frequency governor
// ----------------------------------------------------------------------------
package ltfg_pkg;

    localparam int TICK_W     = 32;
    localparam int LOAD_W     = 7;
    localparam int TEMP_W     = 8;
    localparam int FREQ_W     = 16;
    localparam int CORE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // busy ticks times 100 fits in tick width plus load width
    localparam int ALU_W = TICK_W + LOAD_W;

    localparam int CORES_DEF = 3;

    localparam logic [LOAD_W-1:0] LOAD_MAX = LOAD_W'(100);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_LIMIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_LOAD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODERATE_LOAD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_FREQ      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_FREQ     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_FREQ      = 3'd6;

    // reset values
    localparam logic [TEMP_W-1:0] HOT_LIMIT_RST     = 8'd80;
    localparam logic [TEMP_W-1:0] COOL_LIMIT_RST    = 8'd50;
    localparam logic [LOAD_W-1:0] BUSY_LOAD_RST     = 7'd80;
    localparam logic [LOAD_W-1:0] MODERATE_LOAD_RST = 7'd30;
    localparam logic [FREQ_W-1:0] LOW_FREQ_RST      = 16'd2000;
    localparam logic [FREQ_W-1:0] HIGH_FREQ_RST     = 16'd3200;
    localparam logic [FREQ_W-1:0] MID_FREQ_RST      = 16'd2600;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0]   res;
        logic               carry;   // carry out on add, borrow on sub
    } t_alu_rsp;

endpackage

// File: sv/ltfg_alu.sv
// ----------------------------------------------------------------------------
// ltfg_alu
// shared add / subtract unit with carry and borrow out
// ----------------------------------------------------------------------------
module ltfg_alu
    import ltfg_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_W:0] w_full;

    always_comb begin
        case (i_req.op)
            ALU_ADD: w_full = {1'b0, i_req.a} + {1'b0, i_req.b};
            ALU_SUB: w_full = {1'b0, i_req.a} - {1'b0, i_req.b};
            default: w_full = '0;
        endcase
    end

    assign o_rsp.res   = w_full[ALU_W-1:0];
    assign o_rsp.carry = w_full[ALU_W];

endmodule

// File: sv/ltfg_ram.sv
// ----------------------------------------------------------------------------
// ltfg_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ltfg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/load_thermal_frequency_governor.sv
// ----------------------------------------------------------------------------
// load_thermal_frequency_governor
// per core busy percent from cumulative tick counters, plus a temperature
// and load based frequency request on optimize words
// ----------------------------------------------------------------------------
// sequencing: every add, subtract and divide step walks through the one shared
//   39-bit alu (3 sums, 3 differences, 1 compare, 2 multiply steps, 7 divide
//   steps) plus the history write; a zero total difference or a load clamped at
//   100 skips the multiply and divide steps, and an out-of-range core skips all
//   of them and the history write
// throughput: a new word is taken only while the sequencer is idle, so no word
//   is accepted before the last one is finished; a result still held in the
//   output register stalls the last step until it is taken
// reset: synchronous active low; clears per core valid bits (history reads as
//   zero), restores register defaults, empties the output register
// ----------------------------------------------------------------------------
module load_thermal_frequency_governor
    import ltfg_pkg::*;
#(
    parameter int CORES = CORES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_action,
    input  logic [CORE_W-1:0]     i_core,
    input  logic [TICK_W-1:0]     i_user_ticks,
    input  logic [TICK_W-1:0]     i_nice_ticks,
    input  logic [TICK_W-1:0]     i_system_ticks,
    input  logic [TICK_W-1:0]     i_idle_ticks,
    input  logic [TEMP_W-1:0]     i_temperature,

    // result words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [LOAD_W-1:0]     o_load_percent,
    output logic                  o_freq_change,
    output logic [FREQ_W-1:0]     o_freq_mhz
);

    localparam int AW    = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int HW    = 2 * TICK_W;   // history entry: total and idle
    localparam int KW    = $clog2(LOAD_W);
    // times 100 as 64 + 32 + 4
    localparam int SH_A  = 6;
    localparam int SH_B  = 5;
    localparam int SH_C  = 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD1,
        S_ADD2,
        S_ADD3,
        S_TDIFF,
        S_IDIFF,
        S_BUSY,
        S_CMP,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_WB,
        S_DONE
    } t_state;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [TEMP_W-1:0] r_hot_limit;
    logic [TEMP_W-1:0] r_cool_limit;
    logic [LOAD_W-1:0] r_busy_load;
    logic [LOAD_W-1:0] r_moderate_load;
    logic [FREQ_W-1:0] r_low_freq;
    logic [FREQ_W-1:0] r_high_freq;
    logic [FREQ_W-1:0] r_mid_freq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hot_limit     <= HOT_LIMIT_RST;
            r_cool_limit    <= COOL_LIMIT_RST;
            r_busy_load     <= BUSY_LOAD_RST;
            r_moderate_load <= MODERATE_LOAD_RST;
            r_low_freq      <= LOW_FREQ_RST;
            r_high_freq     <= HIGH_FREQ_RST;
            r_mid_freq      <= MID_FREQ_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HOT_LIMIT:     r_hot_limit     <= i_cfg_data[TEMP_W-1:0];
                CFG_COOL_LIMIT:    r_cool_limit    <= i_cfg_data[TEMP_W-1:0];
                CFG_BUSY_LOAD:     r_busy_load     <= i_cfg_data[LOAD_W-1:0];
                CFG_MODERATE_LOAD: r_moderate_load <= i_cfg_data[LOAD_W-1:0];
                CFG_LOW_FREQ:      r_low_freq      <= i_cfg_data[FREQ_W-1:0];
                CFG_HIGH_FREQ:     r_high_freq     <= i_cfg_data[FREQ_W-1:0];
                CFG_MID_FREQ:      r_mid_freq      <= i_cfg_data[FREQ_W-1:0];
                default: ;  // writes past the list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer registers
    // ------------------------------------------------------------------
    t_state             r_state;
    logic [CORES-1:0]   r_valid;       // history entry written since reset
    logic               r_bad;         // core out of range
    logic               r_action;
    logic [AW-1:0]      r_addr;
    logic [TICK_W-1:0]  r_user;
    logic [TICK_W-1:0]  r_nice;
    logic [TICK_W-1:0]  r_sys;
    logic [TICK_W-1:0]  r_idle;
    logic [TEMP_W-1:0]  r_temp;
    logic [TICK_W-1:0]  r_acc;         // running sum, ends as total
    logic [TICK_W-1:0]  r_tdiff;
    logic [TICK_W-1:0]  r_idiff;
    logic [TICK_W-1:0]  r_busy;
    logic [ALU_W-1:0]   r_num;         // busy * 100, then partial remainder
    logic [KW-1:0]      r_k;           // quotient bit being resolved
    logic [LOAD_W-1:0]  r_load;

    logic               r_out_valid;
    logic [LOAD_W-1:0]  r_out_load;
    logic               r_out_change;
    logic [FREQ_W-1:0]  r_out_freq;

    // ------------------------------------------------------------------
    // history memory: {total, idle} per core, unwritten entries read zero
    // ------------------------------------------------------------------
    logic [HW-1:0]      w_rdata;
    logic [TICK_W-1:0]  w_last_total;
    logic [TICK_W-1:0]  w_last_idle;
    logic               w_wb;

    assign w_wb = (r_state == S_WB);

    ltfg_ram #(
        .WIDTH (HW),
        .DEPTH (CORES)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_wb),
        .i_waddr (r_addr),
        .i_wdata ({r_acc, r_idle}),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_last_total = r_valid[r_addr] ? w_rdata[HW-1:TICK_W] : '0;
    assign w_last_idle  = r_valid[r_addr] ? w_rdata[TICK_W-1:0]  : '0;

    // ------------------------------------------------------------------
    // shared alu operand selection
    // ------------------------------------------------------------------
    t_alu_req w_req;
    t_alu_rsp w_rsp;

    function automatic logic [ALU_W-1:0] ext(input logic [TICK_W-1:0] v);
        ext = {{LOAD_W{1'b0}}, v};
    endfunction

    always_comb begin
        w_req.op = ALU_ADD;
        w_req.a  = '0;
        w_req.b  = '0;
        case (r_state)
            S_ADD1: begin
                w_req.a = ext(r_user);
                w_req.b = ext(r_nice);
            end
            S_ADD2: begin
                w_req.a = ext(r_acc);
                w_req.b = ext(r_sys);
            end
            S_ADD3: begin
                w_req.a = ext(r_acc);
                w_req.b = ext(r_idle);
            end
            S_TDIFF: begin
                w_req.op = ALU_SUB;
                w_req.a  = ext(r_acc);
                w_req.b  = ext(w_last_total);
            end
            S_IDIFF: begin
                w_req.op = ALU_SUB;
                w_req.a  = ext(r_idle);
                w_req.b  = ext(w_last_idle);
            end
            S_BUSY: begin
                w_req.op = ALU_SUB;
                w_req.a  = ext(r_tdiff);
                w_req.b  = ext(r_idiff);
            end
            S_CMP: begin
                // no borrow means busy >= total diff, i.e. load of 100 or more
                w_req.op = ALU_SUB;
                w_req.a  = ext(r_busy);
                w_req.b  = ext(r_tdiff);
            end
            S_MUL1: begin
                w_req.a = ext(r_busy) << SH_A;
                w_req.b = ext(r_busy) << SH_B;
            end
            S_MUL2: begin
                w_req.a = r_num;
                w_req.b = ext(r_busy) << SH_C;
            end
            S_DIV: begin
                w_req.op = ALU_SUB;
                w_req.a  = r_num;
                w_req.b  = ext(r_tdiff) << r_k;
            end
            default: ;
        endcase
    end

    ltfg_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // ------------------------------------------------------------------
    // frequency decision on the finished load
    // ------------------------------------------------------------------
    logic              w_hot;
    logic              w_cool;
    logic              w_change;
    logic [FREQ_W-1:0] w_freq;

    assign w_hot  = (r_temp > r_hot_limit);
    assign w_cool = (r_temp < r_cool_limit);

    always_comb begin
        w_change = 1'b0;
        w_freq   = '0;
        if (r_action && !r_bad) begin
            if (w_hot) begin
                w_change = 1'b1;
                w_freq   = r_low_freq;
            end else if (w_cool && (r_load > r_busy_load)) begin
                w_change = 1'b1;
                w_freq   = r_high_freq;
            end else if (!w_cool && (r_load >= r_moderate_load)
                         && (r_load <= r_busy_load)) begin
                // not hot here already covers temp <= hot limit
                w_change = 1'b1;
                w_freq   = r_mid_freq;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer and output register
    // ------------------------------------------------------------------
    logic w_accept;
    logic w_out_free;
    logic w_emit;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = (r_state == S_DONE) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new word replaces the one leaving in the same cycle
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_action <= i_action;
                        r_addr   <= AW'(i_core);
                        r_user   <= i_user_ticks;
                        r_nice   <= i_nice_ticks;
                        r_sys    <= i_system_ticks;
                        r_idle   <= i_idle_ticks;
                        r_temp   <= i_temperature;
                        r_load   <= '0;
                        if ({{(32-CORE_W){1'b0}}, i_core} >= 32'(CORES)) begin
                            r_bad   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_bad   <= 1'b0;
                            r_state <= S_ADD1;
                        end
                    end
                end
                S_ADD1: begin
                    r_acc   <= w_rsp.res[TICK_W-1:0];
                    r_state <= S_ADD2;
                end
                S_ADD2: begin
                    r_acc   <= w_rsp.res[TICK_W-1:0];
                    r_state <= S_ADD3;
                end
                S_ADD3: begin
                    r_acc   <= w_rsp.res[TICK_W-1:0];
                    r_state <= S_TDIFF;
                end
                S_TDIFF: begin
                    r_tdiff <= w_rsp.res[TICK_W-1:0];
                    r_state <= S_IDIFF;
                end
                S_IDIFF: begin
                    r_idiff <= w_rsp.res[TICK_W-1:0];
                    r_state <= S_BUSY;
                end
                S_BUSY: begin
                    r_busy  <= w_rsp.res[TICK_W-1:0];
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_tdiff == '0) begin
                        r_load  <= '0;
                        r_state <= S_WB;
                    end else if (!w_rsp.carry) begin
                        // clamp
                        r_load  <= LOAD_MAX;
                        r_state <= S_WB;
                    end else begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_num   <= w_rsp.res;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    // quotient is below 100 here, so load width bits suffice
                    r_num   <= w_rsp.res;
                    r_k     <= KW'(LOAD_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!w_rsp.carry) begin
                        r_num       <= w_rsp.res;
                        r_load[r_k] <= 1'b1;
                    end
                    if (r_k == '0) begin
                        r_state <= S_WB;
                    end else begin
                        r_k <= r_k - 1'b1;
                    end
                end
                S_WB: begin
                    r_valid[r_addr] <= 1'b1;
                    r_state         <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_load   <= r_load;
                        r_out_change <= w_change;
                        r_out_freq   <= w_freq;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_load_percent = r_out_load;
    assign o_freq_change  = r_out_change;
    assign o_freq_mhz     = r_out_freq;

endmodule

// File: bench/tb_load_thermal_frequency_governor.sv
// ----------------------------------------------------------------------------
// tb_load_thermal_frequency_governor
// self-checking bench: per-core counter words go in through a valid/ready
// driver, a local predictor tracks tick history and thresholds, and every
// result word is compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_load_thermal_frequency_governor import ltfg_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 3;
    localparam int PHASES           = 8;
    localparam int RANDOM_PER_PHASE = 225;
    localparam int DRAIN_CYCLES     = 25;
    localparam int HOLD_CYCLES      = 400;   // long receiver back-off
    localparam int WATCHDOG_LIMIT   = 3000;  // covers the back-off with margin
    localparam int MAX_REPORTS      = 40;
    localparam int PAUSE_SOLO       = 55;
    localparam int PAUSE_BOTH       = 32;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // one input word
    typedef struct packed {
        logic               action;
        logic [CORE_W-1:0]  core;
        logic [TICK_W-1:0]  user;
        logic [TICK_W-1:0]  nice;
        logic [TICK_W-1:0]  sys;
        logic [TICK_W-1:0]  idle;
        logic [TEMP_W-1:0]  temp;
    } t_gov_word;

    // one result word
    typedef struct packed {
        logic [LOAD_W-1:0]  load;
        logic               change;
        logic [FREQ_W-1:0]  mhz;
    } t_gov_result;

    // clock, reset and block ports
    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  out_ready = 1'b0;
    t_gov_word             offered = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [LOAD_W-1:0]     o_load_percent;
    logic                  o_freq_change;
    logic [FREQ_W-1:0]     o_freq_mhz;

    // stimulus and checking state
    t_gov_word   pending_words[$];
    t_gov_result expected_results[$];
    t_idle_mode  idle_mode = IDLE_NONE;
    bit          took_word = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatch_count = 0;

    // predictor copy of the per-core history and the registers
    logic [TICK_W-1:0] core_total[CORES_DEF];
    logic [TICK_W-1:0] core_idle[CORES_DEF];
    logic [TEMP_W-1:0] hot_thr      = HOT_LIMIT_RST;
    logic [TEMP_W-1:0] cool_thr     = COOL_LIMIT_RST;
    logic [LOAD_W-1:0] busy_thr     = BUSY_LOAD_RST;
    logic [LOAD_W-1:0] moderate_thr = MODERATE_LOAD_RST;
    logic [FREQ_W-1:0] low_mhz      = LOW_FREQ_RST;
    logic [FREQ_W-1:0] high_mhz     = HIGH_FREQ_RST;
    logic [FREQ_W-1:0] mid_mhz      = MID_FREQ_RST;

    // counters last sent per core, so well-formed words can advance them
    logic [TICK_W-1:0] sent_user[CORES_DEF];
    logic [TICK_W-1:0] sent_nice[CORES_DEF];
    logic [TICK_W-1:0] sent_sys[CORES_DEF];
    logic [TICK_W-1:0] sent_idle[CORES_DEF];

    load_thermal_frequency_governor #(
        .CORES (CORES_DEF)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (offered.action),
        .i_core         (offered.core),
        .i_user_ticks   (offered.user),
        .i_nice_ticks   (offered.nice),
        .i_system_ticks (offered.sys),
        .i_idle_ticks   (offered.idle),
        .i_temperature  (offered.temp),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_load_percent (o_load_percent),
        .o_freq_change  (o_freq_change),
        .o_freq_mhz     (o_freq_mhz)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // busy percent since the last sample of the core, then the frequency rule
    function automatic t_gov_result next_load_and_freq(t_gov_word w);
        t_gov_result       r;
        logic [TICK_W-1:0] total;
        logic [TICK_W-1:0] d_total;
        logic [TICK_W-1:0] d_idle;
        logic [TICK_W-1:0] d_busy;
        logic [63:0]       pct;
        r = '0;
        // out-of-range core: history untouched, all-zero word
        if (w.core >= CORES_DEF)
            return r;
        total   = w.user + w.nice + w.sys + w.idle;
        d_total = total - core_total[w.core];
        d_idle  = w.idle - core_idle[w.core];
        d_busy  = d_total - d_idle;
        core_total[w.core] = total;
        core_idle[w.core]  = w.idle;
        // idle ahead of total wraps d_busy huge, so the clamp catches it
        if (d_total != '0) begin
            pct    = (64'(d_busy) * 64'd100) / 64'(d_total);
            r.load = (pct > 64'd100) ? LOAD_MAX : pct[LOAD_W-1:0];
        end
        // first matching rule wins; sample-only words never request a change
        if (w.action) begin
            if (w.temp > hot_thr) begin
                r.change = 1'b1;
                r.mhz    = low_mhz;
            end else if (w.temp < cool_thr && r.load > busy_thr) begin
                r.change = 1'b1;
                r.mhz    = high_mhz;
            end else if (w.temp >= cool_thr && w.temp <= hot_thr &&
                         r.load >= moderate_thr && r.load <= busy_thr) begin
                r.change = 1'b1;
                r.mhz    = mid_mhz;
            end
        end
        return r;
    endfunction

    // random back-pressure for either side of the block
    function automatic bit pause_now(bit receiver_side);
        case (idle_mode)
            IDLE_SENDER:   return !receiver_side && ($urandom_range(99) < PAUSE_SOLO);
            IDLE_RECEIVER: return receiver_side && ($urandom_range(99) < PAUSE_SOLO);
            IDLE_BOTH:     return $urandom_range(99) < PAUSE_BOTH;
            default:       return 1'b0;
        endcase
    endfunction

    task automatic add_word(logic act, logic [CORE_W-1:0] c,
                            logic [TICK_W-1:0] u, logic [TICK_W-1:0] n,
                            logic [TICK_W-1:0] s, logic [TICK_W-1:0] i,
                            logic [TEMP_W-1:0] t);
        t_gov_word w;
        w = '{action: act, core: c, user: u, nice: n, sys: s, idle: i, temp: t};
        pending_words.push_back(w);
        if (c < CORES_DEF) begin
            sent_user[c] = u;
            sent_nice[c] = n;
            sent_sys[c]  = s;
            sent_idle[c] = i;
        end
    endtask

    // advance a core by a busy and an idle tick count, busy split at random
    task automatic add_delta(logic act, logic [CORE_W-1:0] c,
                             logic [TICK_W-1:0] d_busy, logic [TICK_W-1:0] d_idle,
                             logic [TEMP_W-1:0] t);
        logic [TICK_W-1:0] du;
        logic [TICK_W-1:0] dn;
        du = $urandom_range(d_busy);
        dn = $urandom_range(d_busy - du);
        add_word(act, c, sent_user[c] + du, sent_nice[c] + dn,
                 sent_sys[c] + (d_busy - du - dn), sent_idle[c] + d_idle, t);
    endtask

    task automatic add_random_word();
        int unsigned       pick;
        int unsigned       k;
        logic [CORE_W-1:0] c;
        logic [TICK_W-1:0] d_total;
        logic [TICK_W-1:0] d_busy;
        logic [TEMP_W-1:0] t;
        logic              act;
        pick = $urandom_range(99);
        c    = CORE_W'($urandom_range(CORES_DEF - 1));
        act  = ($urandom_range(3) != 0);
        // temperatures cluster on both limits so every rule edge is hit
        case ($urandom_range(3))
            0:       t = cool_thr + TEMP_W'($urandom_range(2)) - 8'd1;
            1:       t = hot_thr + TEMP_W'($urandom_range(2)) - 8'd1;
            default: t = TEMP_W'($urandom);
        endcase
        if (pick < 6) begin
            // core index past the last core
            add_word(act, CORE_W'(CORES_DEF + $urandom_range(3 - CORES_DEF)),
                     $urandom, $urandom, $urandom, $urandom, t);
        end else if (pick < 14) begin
            // raw counters: wraps, backward steps, idle ahead of total
            add_word(act, c, $urandom, $urandom, $urandom, $urandom, t);
        end else if (pick < 20) begin
            // counters unchanged, zero total difference
            add_delta(act, c, '0, '0, t);
        end else begin
            if (pick < 50) begin
                // 100 ticks, load on a band edge or at random
                d_total = 32'd100;
                case ($urandom_range(2))
                    0:       d_busy = busy_thr + $urandom_range(2) - 1;
                    1:       d_busy = moderate_thr + $urandom_range(2) - 1;
                    default: d_busy = $urandom_range(100);
                endcase
                if (d_busy > d_total)
                    d_busy = d_total;
            end else begin
                k       = $urandom_range(31);
                d_total = $urandom_range(32'h1 << k, 1);
                d_busy  = $urandom_range(d_total);
            end
            add_delta(act, c, d_busy, d_total - d_busy, t);
        end
    endtask

    // quiet point: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(val);
        case (idx)
            CFG_HOT_LIMIT:     hot_thr      = TEMP_W'(val);
            CFG_COOL_LIMIT:    cool_thr     = TEMP_W'(val);
            CFG_BUSY_LOAD:     busy_thr     = LOAD_W'(val);
            CFG_MODERATE_LOAD: moderate_thr = LOAD_W'(val);
            CFG_LOW_FREQ:      low_mhz      = FREQ_W'(val);
            CFG_HIGH_FREQ:     high_mhz     = FREQ_W'(val);
            CFG_MID_FREQ:      mid_mhz      = FREQ_W'(val);
            default: ;
        endcase
    endtask

    task automatic program_regs(int unsigned hot, int unsigned cool, int unsigned busy,
                                int unsigned moderate, int unsigned low,
                                int unsigned high, int unsigned mid);
        write_reg(CFG_HOT_LIMIT, hot);
        write_reg(CFG_COOL_LIMIT, cool);
        write_reg(CFG_BUSY_LOAD, busy);
        write_reg(CFG_MODERATE_LOAD, moderate);
        write_reg(CFG_LOW_FREQ, low);
        write_reg(CFG_HIGH_FREQ, high);
        write_reg(CFG_MID_FREQ, mid);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // input side: record the accepted word and predict its result
    always @(posedge i_clk) begin
        took_word = rst_n && in_valid && o_in_ready;
        if (took_word)
            expected_results.push_back(next_load_and_freq(offered));
    end

    // driver: next word goes out on the falling edge once the last one is taken
    always @(negedge i_clk) begin
        if (rst_n && (!in_valid || took_word)) begin
            if (pending_words.size() != 0 && !pause_now(1'b0)) begin
                offered  <= pending_words.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long back-off on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= !pause_now(1'b1);
        end
    end

    // monitor: compare each result word with the oldest prediction, run watchdog
    always @(posedge i_clk) begin
        t_gov_result want;
        if (rst_n && o_out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result word with none expected, actual load %0d",
                             $time, o_load_percent);
            end else begin
                want = expected_results.pop_front();
                if (want.load !== o_load_percent || want.change !== o_freq_change ||
                    want.mhz !== o_freq_mhz) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: expected load %0d change %0d mhz %0d, actual %0d %0d %0d",
                                 $time, want.load, want.change, want.mhz,
                                 o_load_percent, o_freq_change, o_freq_mhz);
                end
            end
        end
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int unsigned hot;
        int unsigned cool;
        int unsigned busy;
        int unsigned moderate;
        for (int c = 0; c < CORES_DEF; c++) begin
            core_total[c] = '0;
            core_idle[c]  = '0;
            sent_user[c]  = '0;
            sent_nice[c]  = '0;
            sent_sys[c]   = '0;
            sent_idle[c]  = '0;
        end
        repeat (RESET_CYCLES) @(negedge i_clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                hot      = $urandom_range(255);
                cool     = ph[0] ? $urandom_range(hot) : $urandom_range(255);
                busy     = $urandom_range(100);
                moderate = ph[0] ? $urandom_range(busy) : $urandom_range(100);
                case (ph)
                    1:       program_regs(0, 0, 0, 0, 0, 0, 0);
                    2:       program_regs(255, 255, 100, 100, 65535, 65535, 65535);
                    6:       program_regs(255, 0, 100, 0, $urandom_range(65535),
                                          $urandom_range(65535), $urandom_range(65535));
                    default: program_regs(hot, cool, busy, moderate, $urandom_range(65535),
                                          $urandom_range(65535), $urandom_range(65535));
                endcase
            end
            idle_mode = t_idle_mode'(ph % 4);

            if (ph == 0) begin
                // reset thresholds: hot 80, cool 50, busy 80, moderate 30
                // no history and no ticks: zero total difference
                add_word(1'b1, 2'd0, '0, '0, '0, '0, 8'd0);
                // fully busy while cold gives the high frequency
                add_delta(1'b1, 2'd0, 32'd100, 32'd0, 8'd0);
                // hottest temperature overrides the load
                add_delta(1'b1, 2'd0, 32'd50, 32'd50, 8'd255);
                // bottom of the middle band at the hot limit
                add_delta(1'b1, 2'd0, 32'd30, 32'd70, HOT_LIMIT_RST);
                // top of the middle band at the cool limit
                add_delta(1'b1, 2'd0, 32'd80, 32'd20, COOL_LIMIT_RST);
                // just busy and just below the cool limit
                add_delta(1'b1, 2'd0, 32'd81, 32'd19, COOL_LIMIT_RST - 8'd1);
                // busy but not cool: no change
                add_delta(1'b1, 2'd0, 32'd81, 32'd19, COOL_LIMIT_RST);
                // just under the middle band: no change
                add_delta(1'b1, 2'd0, 32'd29, 32'd71, 8'd60);
                // one degree over the hot limit
                add_delta(1'b1, 2'd1, 32'd50, 32'd50, HOT_LIMIT_RST + 8'd1);
                // sample only while hot: never a change
                add_delta(1'b0, 2'd1, 32'd90, 32'd10, 8'd255);
                // core past the last one, all ones and all zeros
                add_word(1'b1, 2'd3, '1, '1, '1, '1, 8'hFF);
                add_word(1'b0, 2'd3, '0, '0, '0, '0, 8'h00);
                // all-ones counters, then back to zero across the wrap
                add_word(1'b1, 2'd1, '1, '1, '1, '1, 8'hFF);
                add_word(1'b1, 2'd1, '0, '0, '0, '0, 8'h00);
                // idle ahead of total: the busy difference wraps and clamps
                add_word(1'b1, 2'd2, '0, '0, '0, 32'd100, 8'd40);
                add_word(1'b1, 2'd2, 32'hFFFF_FFA6, '0, '0, 32'd200, 8'd40);
                // widest total difference, then a half-busy huge step
                add_delta(1'b1, 2'd2, 32'hFFFF_FFFF, 32'd0, 8'd10);
                add_delta(1'b1, 2'd2, 32'h8000_0000, 32'h7FFF_FFFF, 8'd65);
                // moderate load inside the band at mid temperature
                add_delta(1'b1, 2'd2, 32'd55, 32'd45, 8'd65);
            end

            // long receiver back-off while the sender keeps offering words
            if (ph == 4)
                hold_request = 1'b1;

            repeat (RANDOM_PER_PHASE) add_random_word();
        end

        wait_drained();
        if (expected_results.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: load_thermal_frequency_governor.f
sv/ltfg_pkg.sv
sv/ltfg_alu.sv
sv/ltfg_ram.sv
sv/load_thermal_frequency_governor.sv
bench/tb_load_thermal_frequency_governor.sv
